// ===== rtl/core/kscan_pkg.sv =====
// Shared types, constants and the key code lookup for the keypad scanner.
// Used by kscan_cfg, kscan_fsm and keypad_scan_blink_controller; no dependencies.
package kscan_pkg;

	localparam int ColW   = 4;
	localparam int RowW   = 4;
	localparam int KeyW   = 5;
	localparam int DebW   = 16;
	localparam int BlinkW = 24;
	localparam int AddrW  = 3;
	localparam int DataW  = 32;

	localparam logic [RowW-1:0]   RowsIdle   = 4'hF;
	localparam logic [KeyW-1:0]   NoKey      = 5'd16;
	localparam logic [DebW-1:0]   DebReset   = 16'd20;
	localparam logic [BlinkW-1:0] BlinkReset = 24'd500;

	localparam logic RegDebounce = 1'b0;
	localparam logic RegBlink    = 1'b1;

	localparam logic [7:0] CodeTable [16] = '{
		8'hE7, 8'hEE, 8'hDE, 8'hBE, 8'hED, 8'hDD, 8'hBD, 8'hEB,
		8'hDB, 8'hBB, 8'h7E, 8'h7D, 8'h7B, 8'h77, 8'hB7, 8'hD7
	};

	typedef struct packed {
		logic [DebW-1:0]   debounce_ticks;
		logic [BlinkW-1:0] blink_half_ticks;
	} cfg_t;

	typedef struct packed {
		logic [KeyW-1:0] key_index;
		logic            key_event;
		logic            led_on;
		logic [ColW-1:0] column_drive;
	} result_t;

	function automatic logic [KeyW-1:0] key_lookup(input logic [7:0] code);
		logic [KeyW-1:0] idx;
		idx = NoKey;
		for (int i = 15; i >= 0; i--) begin
			if (CodeTable[i] == code) begin
				idx = KeyW'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/core/keypad_scan_blink_controller.sv =====
// Top level of the 4x4 keypad scanner with LED blink feedback.
// A result beat passes through the input register and then the result register.
// Throughput: one beat per cycle while the output is not stalled.
// While a result waits, the input register takes one more beat and then the input stalls.
// Reset clears the scan state to the release wait and loads the register defaults.
// Depends on kscan_pkg, kscan_cfg and kscan_fsm.
module keypad_scan_blink_controller import kscan_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [3:0] row_lines
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [3:0] column_drive, [4] led_on,
	                                        // [5] key_event, [10:6] key_index
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	cfg_t            cfg;
	result_t         res;
	result_t         res_s2;
	logic            valid_s1, valid_s2;
	logic [RowW-1:0] rows_s1;
	logic            advance;

	kscan_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kscan_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rows   (rows_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rows_s1 <= s_axis_tdata[RowW-1:0];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'b0, res_s2.key_index, res_s2.key_event, res_s2.led_on,
		res_s2.column_drive};

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |=> valid_s2 && $stable(res_s2))
		else $error("Stalled result was lost or changed");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("Processed tick produced no result");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(rows_s1))
		else $error("Waiting input tick was lost or changed");

endmodule

// ===== rtl/core/kscan_cfg.sv =====
// APB register file holding the debounce and blink period settings.
// Depends on kscan_pkg.
module kscan_cfg import kscan_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic            wr_en;
	logic [DebW-1:0]   debounce_q;
	logic [BlinkW-1:0] blink_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DebReset;
			blink_q    <= BlinkReset;
		end else if (wr_en) begin
			case (paddr[2])
				RegDebounce: debounce_q <= pwdata[DebW-1:0];
				RegBlink:    blink_q    <= pwdata[BlinkW-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			RegDebounce: prdata = DataW'(debounce_q);
			RegBlink:    prdata = DataW'(blink_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.debounce_ticks   = debounce_q;
	assign cfg.blink_half_ticks = blink_q;

endmodule

// ===== rtl/core/kscan_fsm.sv =====
// Scan, debounce, lookup and blink state machine; one tick per step.
// Depends on kscan_pkg.
module kscan_fsm import kscan_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [RowW-1:0] rows,
	input  cfg_t            cfg,
	output result_t         res
);

	typedef enum logic [1:0] {
		PH_RELEASE,
		PH_SCAN,
		PH_DEBOUNCE,
		PH_BLINK
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [1:0]        col_q, col_d;
	logic [DebW-1:0]   deb_q, deb_d;
	logic [KeyW-1:0]   blinks_q, blinks_d, blinks_dec;
	logic [BlinkW-1:0] timer_q, timer_d, half;
	logic              led_q, led_d;
	logic [ColW-1:0]   col_pat;
	logic [KeyW-1:0]   kidx;

	assign half       = (cfg.blink_half_ticks == '0) ? BlinkW'(1) : cfg.blink_half_ticks;
	assign col_pat    = ~(4'b1000 >> col_q);
	assign kidx       = key_lookup({col_pat, rows});
	assign blinks_dec = (blinks_q == '0) ? '0 : blinks_q - KeyW'(1);

	always_comb begin
		phase_d = phase_q;
		col_d   = col_q;
		deb_d   = deb_q;
		blinks_d = blinks_q;
		timer_d = timer_q;
		led_d   = led_q;
		res.column_drive = col_pat;
		res.led_on       = 1'b0;
		res.key_event    = 1'b0;
		res.key_index    = '0;
		case (phase_q)
			PH_RELEASE: begin
				res.column_drive = '0;
				if (rows == RowsIdle) begin
					phase_d = PH_SCAN;
					col_d   = '0;
				end
			end
			PH_SCAN: begin
				if (rows != RowsIdle) begin
					phase_d = PH_DEBOUNCE;
					deb_d   = cfg.debounce_ticks;
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			PH_DEBOUNCE: begin
				if (deb_q != '0) begin
					deb_d = deb_q - DebW'(1);
				end else if (rows != RowsIdle) begin
					res.key_event = 1'b1;
					res.key_index = kidx;
					blinks_d = kidx;
					if (kidx == '0) begin
						phase_d = PH_RELEASE;
					end else begin
						phase_d = PH_BLINK;
						led_d   = 1'b1;
						timer_d = half;
					end
				end else begin
					phase_d = PH_SCAN;
					col_d   = col_q + 2'd1;
				end
			end
			PH_BLINK: begin
				res.led_on = led_q;
				if (timer_q > BlinkW'(1)) begin
					timer_d = timer_q - BlinkW'(1);
				end else if (led_q) begin
					led_d   = 1'b0;
					timer_d = half;
				end else begin
					blinks_d = blinks_dec;
					if (blinks_dec == '0) begin
						phase_d = PH_RELEASE;
						timer_d = '0;
					end else begin
						led_d   = 1'b1;
						timer_d = half;
					end
				end
			end
			default: phase_d = PH_RELEASE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RELEASE;
			col_q    <= '0;
			deb_q    <= '0;
			blinks_q <= '0;
			timer_q  <= '0;
			led_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			col_q    <= col_d;
			deb_q    <= deb_d;
			blinks_q <= blinks_d;
			timer_q  <= timer_d;
			led_q    <= led_d;
		end
	end

	a_led_only_blinking: assert property (@(posedge clk) disable iff (!arst_n)
		led_q |-> phase_q == PH_BLINK)
		else $error("LED state set outside the blink phase");

	a_blink_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BLINK |-> blinks_q != '0)
		else $error("Blink phase entered with no blinks left");

	a_event_index: assert property (@(posedge clk) disable iff (!arst_n)
		!res.key_event |-> res.key_index == '0)
		else $error("Key index nonzero without a key event");

	a_detect_debounce: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_SCAN && rows != RowsIdle |=> phase_q == PH_DEBOUNCE)
		else $error("Row detection did not start the debounce wait");

endmodule

// ===== test/tb_keypad_scan_blink_controller.sv =====
// Self-checking testbench for keypad_scan_blink_controller: row beats in, one result beat out.
// Holds its own scan and blink predictor in a small scoreboard class.
// Depends on kscan_pkg and the keypad_scan_blink_controller RTL.
module tb_keypad_scan_blink_controller;
	import kscan_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 2000;
	localparam int HoldCycles = 300;

	typedef enum logic [1:0] {WaitRelease, Scanning, Debouncing, Blinking} scan_stage_t;

	class keypad_tracker;
		logic [DebW-1:0]   debounce_ticks;
		logic [BlinkW-1:0] blink_half;
		scan_stage_t       stage;
		logic [1:0]        col;
		logic [DebW-1:0]   deb_left;
		logic [KeyW-1:0]   blinks_left;
		logic [BlinkW-1:0] blink_timer;
		logic              led_lit;
		result_t           pending_results[$];
		int                errors;

		function new();
			debounce_ticks = DebReset;
			blink_half = BlinkReset;
			stage = WaitRelease;
			col = '0;
			deb_left = '0;
			blinks_left = '0;
			blink_timer = '0;
			led_lit = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			if (idx == RegDebounce) begin
				debounce_ticks = value[DebW-1:0];
			end else begin
				blink_half = value[BlinkW-1:0];
			end
		endfunction

		function logic [ColW-1:0] column_pattern();
			return ~(4'b1000 >> col);
		endfunction

		function logic [BlinkW-1:0] half_period();
			return (blink_half == '0) ? BlinkW'(1) : blink_half;
		endfunction

		function logic [KeyW-1:0] key_of(logic [7:0] code);
			logic [KeyW-1:0] idx;
			idx = NoKey;
			for (int i = 0; i < 16; i++) begin
				if (CodeTable[i] == code && idx == NoKey) begin
					idx = KeyW'(i);
				end
			end
			return idx;
		endfunction

		function bit settled();
			return stage == WaitRelease || stage == Scanning;
		endfunction

		function void note_rows(logic [RowW-1:0] rows);
			result_t r;
			r = '0;
			case (stage)
				WaitRelease: begin
					if (rows == RowsIdle) begin
						stage = Scanning;
						col = '0;
					end
				end
				Scanning: begin
					r.column_drive = column_pattern();
					if (rows != RowsIdle) begin
						stage = Debouncing;
						deb_left = debounce_ticks;
					end else begin
						col++;
					end
				end
				Debouncing: begin
					r.column_drive = column_pattern();
					if (deb_left != '0) begin
						deb_left--;
					end else if (rows != RowsIdle) begin
						r.key_event = 1'b1;
						r.key_index = key_of({column_pattern(), rows});
						blinks_left = r.key_index;
						if (r.key_index == '0) begin
							stage = WaitRelease;
						end else begin
							stage = Blinking;
							led_lit = 1'b1;
							blink_timer = half_period();
						end
					end else begin
						stage = Scanning;
						col++;
					end
				end
				default: begin
					r.column_drive = column_pattern();
					r.led_on = led_lit;
					if (blink_timer > 1) begin
						blink_timer--;
					end else if (led_lit) begin
						led_lit = 1'b0;
						blink_timer = half_period();
					end else begin
						if (blinks_left != '0) begin
							blinks_left--;
						end
						if (blinks_left == '0) begin
							stage = WaitRelease;
							blink_timer = '0;
						end else begin
							led_lit = 1'b1;
							blink_timer = half_period();
						end
					end
				end
			endcase
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [15:0] data);
			result_t want;
			result_t got;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat %h arrived with nothing expected", $time, data);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			got = result_t'(data[10:0]);
			compare_field("column_drive", 8'(want.column_drive), 8'(got.column_drive));
			compare_field("led_on", 8'(want.led_on), 8'(got.led_on));
			compare_field("key_event", 8'(want.key_event), 8'(got.key_event));
			compare_field("key_index", 8'(want.key_index), 8'(got.key_index));
			compare_field("tdata padding", 8'h00, 8'(data[15:11]));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;  // [3:0] row_lines
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [15:0]      m_axis_tdata;  // [3:0] column_drive, [4] led_on, [5] key_event,
	                                 // [10:6] key_index
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	keypad_tracker   tracker = new();
	logic [RowW-1:0] scripted_rows[$];
	logic [7:0]      target_code;
	int              send_idle_pct;
	int              recv_stall_pct;
	bit              safe_keys;
	bit              hold_wanted;

	keypad_scan_blink_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly a pressed key that answers only on its own column, with some noise and bounce.
	function automatic void choose_target();
		logic [1:0] c;
		c = 2'($urandom);
		if (safe_keys) begin
			target_code = CodeTable[0];
		end else if ($urandom_range(4) != 0) begin
			target_code = CodeTable[$urandom_range(15)];
		end else begin
			target_code = {~(4'b1000 >> c), 4'($urandom_range(14))};
		end
	endfunction

	function automatic logic [RowW-1:0] pick_rows();
		logic [RowW-1:0] rows;
		rows = RowW'($urandom);
		case (tracker.stage)
			WaitRelease: begin
				choose_target();
				if ($urandom_range(7) != 0) begin
					rows = RowsIdle;
				end
			end
			Scanning: begin
				if (safe_keys || $urandom_range(9) != 0) begin
					rows = (tracker.column_pattern() == target_code[7:4]) ?
						target_code[3:0] : RowsIdle;
				end
			end
			Debouncing: begin
				if (tracker.deb_left == '0) begin
					rows = ($urandom_range(5) == 0) ? RowsIdle : target_code[3:0];
				end
			end
			default: ;
		endcase
		return rows;
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == RegDebounce) ? 32'h0000_FFFF : 32'h00FF_FFFF;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (value & mask)) begin
			$display("%0t: register %0d read back expected %h, got %h",
				$time, idx, value & mask, prdata);
			tracker.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.set_register(idx, value);
	endtask

	task automatic send_rows(input int goal);
		int offered;
		bit busy;
		logic [RowW-1:0] rows;
		offered = 0;
		busy = 1'b0;
		while (busy || scripted_rows.size() != 0 || offered < goal || !tracker.settled()) begin
			@(posedge clk);
			if (busy && s_axis_tready) begin
				tracker.note_rows(s_axis_tdata[RowW-1:0]);
				busy = 1'b0;
			end
			if (!busy) begin
				if ((scripted_rows.size() != 0 || offered < goal || !tracker.settled()) &&
				    $urandom_range(99) >= send_idle_pct) begin
					if (scripted_rows.size() != 0) begin
						rows = scripted_rows.pop_front();
					end else begin
						offered++;
						rows = pick_rows();
					end
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0000, rows};
					busy = 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [31:0] deb, input logic [31:0] half,
	                         input int send_idle, input int recv_stall, input int goal,
	                         input bit safe, input bit hold);
		write_reg(RegDebounce, deb);
		write_reg(RegBlink, half);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		safe_keys = safe;
		if (hold) begin
			hold_wanted = 1'b1;
		end
		send_rows(goal);
		while (tracker.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				tracker.check_beat(m_axis_tdata);
			end
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		safe_keys = 1'b0;
		hold_wanted = 1'b0;
		target_code = CodeTable[0];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Release wait, full column wrap, a rejected bounce, a key that blinks once with
		// the zero half period, and a key with index zero that returns straight to release.
		scripted_rows = '{4'h0, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hE, 4'hF, 4'hF, 4'hF,
		                  4'hE, 4'hE, 4'h8, 4'h5, 4'hF, 4'hF, 4'hF, 4'hF, 4'h7, 4'h7};
		run_phase(32'd0, 32'd0, 0, 0, 0, 1'b0, 1'b0);
		run_phase(32'h5A5A_0003, 32'hFF00_0001, 0, 0, 200, 1'b0, 1'b1);
		run_phase(32'd64, 32'd2, 0, 0, 5, 1'b0, 1'b0);
		run_phase(32'd1, 32'd16777215, 0, 0, 20, 1'b1, 1'b0);
		run_phase(32'd2, 32'd1, 62, 0, 250, 1'b0, 1'b0);
		run_phase(32'd0, 32'd3, 0, 62, 250, 1'b0, 1'b0);
		run_phase(32'd5, 32'd1, 32, 32, 250, 1'b0, 1'b0);
		run_phase(32'd7, 32'd2, 0, 0, 80, 1'b0, 1'b0);

		repeat (8) @(posedge clk);
		if (tracker.pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, tracker.pending_results.size());
			tracker.errors++;
		end
		if (tracker.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/kscan_pkg.sv
rtl/core/kscan_cfg.sv
rtl/core/kscan_fsm.sv
rtl/core/keypad_scan_blink_controller.sv
test/tb_keypad_scan_blink_controller.sv
